// File: rtl/fadd_pkg.sv
// Shared types and constants for the binary32 adder.
// No dependencies.
package fadd_pkg;

    localparam logic [31:0] EXP_MASK    = 32'h7F80_0000;
    localparam logic [31:0] FRAC_MASK   = 32'h007F_FFFF;
    localparam logic [31:0] QUIET_NAN   = 32'h7FC0_0000;
    localparam logic [31:0] INVALID_NAN = 32'hFFC0_0000;

    // Classified word handed from the front to the back end.
    typedef struct packed {
        logic        special;   // result already known
        logic [31:0] special_val;
        logic        sign;
        logic        eff_sub;
        logic [7:0]  ex;
        logic [26:0] mx;        // big significand with three extra bits
        logic [26:0] my;        // small significand, aligned, sticky folded in
    } fadd_word_t;

endpackage

// File: rtl/fadd_front.sv
// Front end: classify operands, order by magnitude, align the smaller one.
// Depends on fadd_pkg.
module fadd_front
    import fadd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        out_valid,
    input  logic        out_ready,
    output fadd_word_t  out_word
);

    logic       valid_reg;
    fadd_word_t word_reg;
    fadd_word_t word_next;

    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [31:0] big, lit_op;
    logic [7:0]  ex, ey, d;
    logic [26:0] mx, my, my_sh;
    logic        lost;

    always_comb
    begin
        a_nan  = (op_a & EXP_MASK) == EXP_MASK && (op_a & FRAC_MASK) != 32'd0;
        b_nan  = (op_b & EXP_MASK) == EXP_MASK && (op_b & FRAC_MASK) != 32'd0;
        a_inf  = (op_a & EXP_MASK) == EXP_MASK && (op_a & FRAC_MASK) == 32'd0;
        b_inf  = (op_b & EXP_MASK) == EXP_MASK && (op_b & FRAC_MASK) == 32'd0;
        a_zero = op_a[30:0] == 31'd0;
        b_zero = op_b[30:0] == 31'd0;
        if (op_a[30:0] < op_b[30:0])
        begin
            big = op_b; lit_op = op_a;
        end
        else
        begin
            big = op_a; lit_op = op_b;
        end
        ex = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        ey = (lit_op[30:23] == 8'd0) ? 8'd1 : lit_op[30:23];
        mx = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        my = {(lit_op[30:23] != 8'd0), lit_op[22:0], 3'b000};
        d  = ex - ey;
        // Align with sticky collection
        lost = 1'b0;
        if (d >= 8'd27)
        begin
            my_sh = {26'd0, (my != 27'd0)};
        end
        else
        begin
            lost  = (my & ((27'd1 << d[4:0]) - 27'd1)) != 27'd0;
            my_sh = (my >> d[4:0]) | {26'd0, lost};
        end

        word_next.sign    = big[31];
        word_next.eff_sub = op_a[31] ^ op_b[31];
        word_next.ex      = ex;
        word_next.mx      = mx;
        word_next.my      = my_sh;
        word_next.special = 1'b1;
        if (b_nan)
            word_next.special_val = op_b | QUIET_NAN;
        else if (a_nan)
            word_next.special_val = op_a | QUIET_NAN;
        else if (a_inf && b_inf)
            word_next.special_val = (op_a[31] ^ op_b[31]) ? INVALID_NAN : op_a;
        else if (a_inf)
            word_next.special_val = op_a;
        else if (b_inf)
            word_next.special_val = op_b;
        else if (a_zero && b_zero)
            word_next.special_val = op_a & op_b & 32'h8000_0000;
        else if (a_zero)
            word_next.special_val = op_b;
        else if (b_zero)
            word_next.special_val = op_a;
        else if (op_a[30:0] == op_b[30:0] && (op_a[31] ^ op_b[31]))
            word_next.special_val = 32'd0;
        else
        begin
            word_next.special     = 1'b0;
            word_next.special_val = 32'd0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // Advance the stage when it is empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

// File: rtl/fadd_queue.sv
// Two-entry queue between front and back end.
// Depends on fadd_pkg.
module fadd_queue
    import fadd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  fadd_word_t in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output fadd_word_t out_word
);

    fadd_word_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_word  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Track pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_word;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost a word");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !out_valid)
        else $error("empty queue shows valid");

endmodule

// File: rtl/fadd_back.sv
// Back end: add or subtract, normalize, round to nearest even, pack.
// Two registered stages with skid-free elastic flow. Depends on fadd_pkg.
module fadd_back
    import fadd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fadd_word_t  in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sum
);

    // Stage 1: raw sum and leading-zero count
    logic        s1_valid_reg;
    logic        s1_special_reg;
    logic [31:0] s1_special_val_reg;
    logic        s1_sign_reg;
    logic [8:0]  s1_ex_reg;
    logic [27:0] s1_m_reg;
    logic [4:0]  s1_lz_reg;
    logic        s1_ready;

    logic [27:0] m_raw, m_next;
    logic [8:0]  ex_next;
    logic [4:0]  lz_next;
    logic        lz_found;

    always_comb
    begin
        ex_next = {1'b0, in_word.ex};
        if (!in_word.eff_sub)
        begin
            m_raw = {1'b0, in_word.mx} + {1'b0, in_word.my};
            if (m_raw[27])
            begin
                m_next  = (m_raw >> 1) | {27'd0, m_raw[0]};
                ex_next = ex_next + 9'd1;
            end
            else
                m_next = m_raw;
        end
        else
        begin
            m_raw  = {1'b0, in_word.mx} - {1'b0, in_word.my};
            m_next = m_raw;
        end
        // Count leading zeros from bit 26 down
        lz_next  = 5'd0;
        lz_found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!lz_found && m_next[i])
            begin
                lz_found = 1'b1;
                lz_next  = 5'(26 - i);
            end
        end
        if (!lz_found)
            lz_next = 5'd26;
    end

    // Stage 2: shift, round and pack
    logic        s2_valid_reg;
    logic [31:0] s2_sum_reg;
    logic [31:0] res_next;
    logic [8:0]  sh;
    logic [8:0]  ex2;
    logic [27:0] m2;
    logic [24:0] mr;
    logic [2:0]  grs;

    always_comb
    begin
        // Shift by leading zeros, limited so the exponent stays at one
        if ({4'd0, s1_lz_reg} < s1_ex_reg - 9'd1)
            sh = {4'd0, s1_lz_reg};
        else
            sh = s1_ex_reg - 9'd1;
        m2  = s1_m_reg << sh[4:0];
        ex2 = s1_ex_reg - sh;
        grs = m2[2:0];
        mr  = {1'b0, m2[26:3]};
        if (grs > 3'd4 || (grs == 3'd4 && mr[0]))
            mr = mr + 25'd1;
        if (mr[24])
        begin
            mr  = mr >> 1;
            ex2 = ex2 + 9'd1;
        end
        if (s1_special_reg)
            res_next = s1_special_val_reg;
        else if (ex2 >= 9'd255)
            res_next = {s1_sign_reg, EXP_MASK[30:0]};
        else if (!mr[23])
            res_next = {s1_sign_reg, 8'd0, mr[22:0]};
        else
            res_next = {s1_sign_reg, ex2[7:0], mr[22:0]};
    end

    logic s2_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign sum       = s2_sum_reg;

    // Advance the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_special_reg     <= in_word.special;
            s1_special_val_reg <= in_word.special_val;
            s1_sign_reg        <= in_word.sign;
            s1_ex_reg          <= ex_next;
            s1_m_reg           <= m_next;
            s1_lz_reg          <= lz_next;
        end
        if (s2_ready && s1_valid_reg)
            s2_sum_reg <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> s2_valid_reg && $stable(s2_sum_reg))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_special_reg) |-> s1_ex_reg >= 9'd1)
        else $error("exponent below one");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("stage one dropped a word");

endmodule

// File: rtl/binary32_float_adder_core.sv
// Top level of the binary32 adder: front end, queue, back end.
// Depends on fadd_pkg, fadd_front, fadd_queue, fadd_back.
//
// Adds two IEEE 754 binary32 operands with round to nearest even, full
// subnormal support, NaN quieting (op_b wins) and signed overflow to
// infinity. One word is accepted per clock when the output is not stalled;
// a result passes the front register, a queue entry and two back stages
// before it is presented. The two-entry queue lets the front accept while
// the back end is held by the consumer.
module binary32_float_adder_core
    import fadd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] sum
);

    logic       f_valid, f_ready, q_valid, q_ready;
    fadd_word_t f_word, q_word;

    fadd_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .op_a, .op_b,
        .out_valid(f_valid), .out_ready(f_ready), .out_word(f_word)
    );

    fadd_queue u_queue (
        .clk, .rst_n, .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    fadd_back u_back (
        .clk, .rst_n, .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
        .out_valid, .out_ready, .sum
    );

endmodule

// File: dv/fadd_sum_checker.sv
// Checker for the binary32 adder: watches both channels, predicts each sum
// and compares it with what the core returns. Depends on nothing but the ports.
`timescale 1ns / 100ps

module fadd_sum_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] sum,
    output int          fail_count,
    output int          pending_sums
);

    localparam logic [31:0] EXP_ALL  = 32'h7F80_0000;
    localparam logic [31:0] FRAC_ALL = 32'h007F_FFFF;
    localparam logic [31:0] HIDDEN   = 32'h0080_0000;
    localparam logic [31:0] QUIET    = 32'h7FC0_0000;
    localparam logic [31:0] INVALID  = 32'hFFC0_0000;
    localparam logic [31:0] SIGN     = 32'h8000_0000;

    logic [31:0] sum_queue[$];

    function automatic logic [31:0] round_finite_sum(logic [31:0] a, logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic [31:0] sgn;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] m;
        logic [31:0] grs;
        int          ex;
        int          ey;
        int          d;
        big = a;
        lit = b;
        if (a[30:0] < b[30:0])
        begin
            big = b;
            lit = a;
        end
        // exact cancellation gives +0
        if (big[30:0] == lit[30:0] && big[31] != lit[31])
            return 32'h0;
        sgn = big & SIGN;
        ex = big[30:23];
        ey = lit[30:23];
        mx = big & FRAC_ALL;
        my = lit & FRAC_ALL;
        if (ex == 0) ex = 1; else mx |= HIDDEN;
        if (ey == 0) ey = 1; else my |= HIDDEN;
        mx = mx << 3;
        my = my << 3;
        d = ex - ey;
        // align the smaller operand, folding lost bits into sticky
        if (d >= 27)
            my = (my != 0) ? 32'd1 : 32'd0;
        else if (d > 0)
            my = (my >> d) | ((my & ((32'd1 << d) - 1)) != 0 ? 32'd1 : 32'd0);
        if (a[31] == b[31])
        begin
            m = mx + my;
            if (m[27])
            begin
                m = (m >> 1) | (m & 32'd1);
                ex++;
            end
        end
        else
        begin
            m = mx - my;
            while (m < (32'd1 << 26) && ex > 1)
            begin
                m = m << 1;
                ex--;
            end
        end
        // round to nearest even
        grs = m & 32'd7;
        m = m >> 3;
        if (grs > 4 || (grs == 4 && m[0]))
            m++;
        if (m == (32'd1 << 24))
        begin
            m = m >> 1;
            ex++;
        end
        if (ex >= 255)
            return sgn | EXP_ALL;
        if ((m & HIDDEN) == 0)
            return sgn | (m & FRAC_ALL);
        return sgn | (32'(ex) << 23) | (m & FRAC_ALL);
    endfunction

    function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_inf;
        logic b_inf;
        a_nan = a[30:23] == 8'hFF && a[22:0] != 0;
        b_nan = b[30:23] == 8'hFF && b[22:0] != 0;
        a_inf = a[30:23] == 8'hFF && a[22:0] == 0;
        b_inf = b[30:23] == 8'hFF && b[22:0] == 0;
        if (b_nan) return b | QUIET;
        if (a_nan) return a | QUIET;
        if (a_inf && b_inf) return (a[31] != b[31]) ? INVALID : a;
        if (a_inf) return a;
        if (b_inf) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return a & b & SIGN;
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        return round_finite_sum(a, b);
    endfunction

    assign pending_sums = sum_queue.size();

    // predict on every accepted operand word, check every accepted sum word
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            fail_count <= 0;
            sum_queue.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                sum_queue.push_back(predict_sum(op_a, op_b));
            if (out_valid && out_ready)
            begin
                if (sum_queue.size() == 0)
                begin
                    $display("%0t: unexpected sum word, expected none, actual %h",
                             $time, sum);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = sum_queue.pop_front();
                    if (sum !== want)
                    begin
                        $display("%0t: sum mismatch, expected %h, actual %h",
                                 $time, want, sum);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/binary32_float_adder_core_tb.sv
// Testbench top for the binary32 adder: drives operand words under several
// idling phases and gives the verdict. Depends on the core and fadd_sum_checker.
`timescale 1ns / 100ps

module binary32_float_adder_core_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] sum;
    int          fail_count;
    int          pending_sums;
    int          send_idle_pct;
    int          recv_stall_pct;

    binary32_float_adder_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op_a      (op_a),
        .op_b      (op_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum       (sum)
    );

    fadd_sum_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op_a         (op_a),
        .op_b         (op_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sum          (sum),
        .fail_count   (fail_count),
        .pending_sums (pending_sums)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // random backpressure on the result side
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // pick an operand that often lands on a special class or edge value
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'hFF;                       // inf or nan
            1: v[30:23] = 8'h00;                       // zero or subnormal
            2: v[30:0] = 31'h0;                        // signed zero
            3: v[30:23] = 8'hFE;                       // near overflow
            4: v[22:0] = $urandom_range(1) ? 23'h7FFFFF : 23'h0;
            default: ;
        endcase
        return v;
    endfunction

    // present one operand word, hold it until accepted
    task automatic send_word(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op_a     <= a;
        op_b     <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = pick_operand();
            b = pick_operand();
            // near values exercise deep cancellation
            if ($urandom_range(4) == 0)
                b = {~a[31], a[30:0]} ^ 32'($urandom_range(7));
            send_word(a, b);
        end
    endtask

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op_a           = '0;
        op_b           = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: specials, extremes, rounding and subnormal cases
        send_word(32'h7FC0_0001, 32'hFF80_0123);   // both nan, op_b wins
        send_word(32'h7F80_0001, 32'h3F80_0000);   // signaling nan in op_a
        send_word(32'h3F80_0000, 32'h0000_0000);
        send_word(32'h7F80_0000, 32'hFF80_0000);   // inf minus inf
        send_word(32'hFF80_0000, 32'hFF80_0000);
        send_word(32'h7F80_0000, 32'h4000_0000);
        send_word(32'h4000_0000, 32'hFF80_0000);
        send_word(32'h8000_0000, 32'h8000_0000);   // negative zeros
        send_word(32'h8000_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'hC120_0000);
        send_word(32'h3FC0_0000, 32'hBFC0_0000);   // exact cancellation
        send_word(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
        send_word(32'hFF7F_FFFF, 32'hF380_0000);   // negative overflow
        send_word(32'h0000_0001, 32'h0000_0001);   // subnormals
        send_word(32'h007F_FFFF, 32'h0000_0001);   // subnormal to normal
        send_word(32'h0080_0000, 32'h8000_0001);   // normal to subnormal
        send_word(32'h3F80_0000, 32'h3380_0000);   // tie, even kept
        send_word(32'h3F80_0001, 32'h3380_0000);   // tie, round up
        send_word(32'h3F80_0000, 32'hB380_0001);
        send_word(32'h4B7F_FFFF, 32'h3F00_0000);
        send_word(32'h3F80_0000, 32'h0000_0001);   // huge exponent gap
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h3F80_0000, 32'hBF7F_FFFF);   // deep normalization

        send_random(100);

        // let the block drain fully before the idling phases
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums != 0)
            @(posedge clk);

        send_idle_pct = 84;
        send_random(70);
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        send_random(70);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_random(70);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(70);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // end a hung run
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fadd_pkg.sv
rtl/fadd_front.sv
rtl/fadd_queue.sv
rtl/fadd_back.sv
rtl/binary32_float_adder_core.sv
dv/fadd_sum_checker.sv
dv/binary32_float_adder_core_tb.sv
